// ===== sv/assert_macros.svh =====
// Assertion macros used by the envelope generator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/adsr_pkg.sv =====
// Types, constants and the exponential curve table of the ADSR envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

    // Envelope phases, same encoding as the new_phase / phase_now fields
    typedef enum logic [2:0] {
        PH_DISABLED = 3'd0,
        PH_ATTACK   = 3'd1,
        PH_DECAY    = 3'd2,
        PH_SUSTAIN  = 3'd3,
        PH_RELEASE  = 3'd4,
        PH_ENDED    = 3'd5
    } phase_t;

    // Input transaction kinds
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ATTACK_TICKS  = 3'd0;
    localparam logic [2:0] CFG_DECAY_TICKS   = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd2;
    localparam logic [2:0] CFG_RELEASE_TICKS = 3'd3;
    localparam logic [2:0] CFG_EXP_MODE      = 3'd4;

    localparam logic [15:0] HOLD_LENGTH = 16'hFFFF;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;

    // Divider geometry: 24-bit dividend, 16-bit divisor, 8-bit quotient
    localparam int QUOT_W = 8;
    localparam int DEN_W  = 16;
    localparam int NUM_W  = DEN_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADVANCE,
        ST_PREP,
        ST_DIVIDE,
        ST_SHAPE,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic set_phase;
        logic advance;
        logic prep;
        logic shape;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic ramped;
        logic ramp_full;
        logic div_busy;
        logic out_free;
    } dp_status_t;

    typedef logic [7:0] curve_t [256];

    // Shift-and-subtract long division for the table build, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // g[f] = 256 - ceil(256 * exp(-5f/256)), exp summed as a Q56 series.
    // Evaluated once at elaboration only.
    function automatic curve_t build_curve();
        curve_t      tbl;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] ceil_y;
        for (int f = 0; f < 256; f++) begin
            sum  = 64'd1 << 56;
            term = 64'd1 << 56;
            for (int k = 1; k < 80 && term != 64'd0; k++) begin
                term = udiv64(term, 64'(k) * 64'd256) * (64'(f) * 64'd5);
                sum  = sum + term;
            end
            ceil_y = udiv64(64'hFFFF_FFFF_FFFF_FFFF, sum) + 64'd1;
            if (ceil_y > 64'd256)
            begin
                ceil_y = 64'd256;
            end
            tbl[f] = 8'(64'd256 - ceil_y);
        end
        return tbl;
    endfunction

    localparam curve_t CURVE = build_curve();

endpackage

// ===== sv/adsr_div.sv =====
// Restoring divider, one quotient bit per cycle, for dividends below divisor * 256.
`timescale 1ns / 1ps

module adsr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [adsr_pkg::NUM_W-1:0]    numer,
    input  logic [adsr_pkg::DEN_W-1:0]    divisor,
    output logic                          busy,
    output logic [adsr_pkg::QUOT_W-1:0]   quotient
);

    logic [adsr_pkg::DEN_W-1:0]  rem_reg, rem_next;
    logic [adsr_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [adsr_pkg::STEP_W-1:0] step_reg, step_next;
    logic                        busy_reg, busy_next;
    logic [adsr_pkg::DEN_W:0]    trial;
    logic                        fits;

    // Dividend bits shift out of quot_reg as quotient bits shift in
    assign trial = {rem_reg, quot_reg[adsr_pkg::QUOT_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = numer[adsr_pkg::NUM_W-1:adsr_pkg::QUOT_W];
            quot_next = numer[adsr_pkg::QUOT_W-1:0];
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? adsr_pkg::DEN_W'(trial - {1'b0, divisor})
                             : trial[adsr_pkg::DEN_W-1:0];
            quot_next = {quot_reg[adsr_pkg::QUOT_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == adsr_pkg::STEP_W'(adsr_pkg::QUOT_W - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

// ===== sv/adsr_dp.sv =====
// Datapath: configuration registers, envelope state, ramp arithmetic and output register.
`timescale 1ns / 1ps

module adsr_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic [2:0]            new_phase,
    input  adsr_pkg::ctrl_cmd_t   cmd,
    output adsr_pkg::dp_status_t  status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_level,
    output logic [2:0]            out_phase
);

    logic [15:0] attack_ticks_reg;
    logic [15:0] decay_ticks_reg;
    logic [7:0]  sustain_level_reg;
    logic [15:0] release_ticks_reg;
    logic        exp_mode_reg;

    adsr_pkg::phase_t phase_reg, phase_next;
    logic [15:0]      tick_count_reg, tick_count_next;
    logic [15:0]      phase_length_reg, phase_length_next;
    logic [7:0]       ramp_reg, ramp_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_level_reg;
    logic [2:0]       out_phase_reg;

    logic [7:0]                    ramp_range;
    logic                          ramped;
    logic                          live;
    logic                          ramp_full;
    logic [adsr_pkg::NUM_W-1:0]    numer;
    logic                          div_start;
    logic                          div_busy;
    logic [adsr_pkg::QUOT_W-1:0]   quotient;
    logic [15:0]                   scaled;
    logic [7:0]                    level_now;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_ticks_reg  <= '0;
            decay_ticks_reg   <= '0;
            sustain_level_reg <= '0;
            release_ticks_reg <= '0;
            exp_mode_reg      <= 1'b0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                adsr_pkg::CFG_ATTACK_TICKS:  attack_ticks_reg  <= cfg_data;
                adsr_pkg::CFG_DECAY_TICKS:   decay_ticks_reg   <= cfg_data;
                adsr_pkg::CFG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[7:0];
                adsr_pkg::CFG_RELEASE_TICKS: release_ticks_reg <= cfg_data;
                adsr_pkg::CFG_EXP_MODE:      exp_mode_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Ramp range of the current phase
    always_comb
    begin
        case (phase_reg)
            adsr_pkg::PH_ATTACK:  ramp_range = adsr_pkg::LEVEL_MAX;
            adsr_pkg::PH_DECAY:   ramp_range = adsr_pkg::LEVEL_MAX - sustain_level_reg;
            adsr_pkg::PH_RELEASE: ramp_range = sustain_level_reg;
            default:              ramp_range = '0;
        endcase
    end

    assign ramped = phase_reg inside {adsr_pkg::PH_ATTACK, adsr_pkg::PH_DECAY,
                                      adsr_pkg::PH_RELEASE};
    assign live   = ramped || (phase_reg == adsr_pkg::PH_SUSTAIN);
    assign ramp_full = (phase_length_reg == '0) || (tick_count_reg >= phase_length_reg);

    // Linear: range*t/T; exponential: table index 256*t/T
    assign numer = exp_mode_reg ? {tick_count_reg, 8'd0}
                                : adsr_pkg::NUM_W'(ramp_range) * adsr_pkg::NUM_W'(tick_count_reg);
    assign div_start = cmd.prep && ramped && !ramp_full;

    adsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (numer),
        .divisor  (phase_length_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign scaled = 16'(ramp_range) * 16'(adsr_pkg::CURVE[quotient]);

    always_comb
    begin
        case (phase_reg)
            adsr_pkg::PH_DISABLED: level_now = adsr_pkg::LEVEL_MAX;
            adsr_pkg::PH_ATTACK:   level_now = ramp_reg;
            adsr_pkg::PH_DECAY:    level_now = adsr_pkg::LEVEL_MAX - ramp_reg;
            adsr_pkg::PH_SUSTAIN:  level_now = sustain_level_reg;
            adsr_pkg::PH_RELEASE:  level_now = sustain_level_reg - ramp_reg;
            default:               level_now = '0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        phase_length_next = phase_length_reg;
        ramp_next         = ramp_reg;

        if (cmd.set_phase && (new_phase <= 3'(adsr_pkg::PH_ENDED)))
        begin
            phase_next      = adsr_pkg::phase_t'(new_phase);
            tick_count_next = '0;
            case (adsr_pkg::phase_t'(new_phase))
                adsr_pkg::PH_ATTACK:  phase_length_next = attack_ticks_reg;
                adsr_pkg::PH_DECAY:   phase_length_next = decay_ticks_reg;
                adsr_pkg::PH_RELEASE: phase_length_next = release_ticks_reg;
                default:              phase_length_next = adsr_pkg::HOLD_LENGTH;
            endcase
        end

        // Phase expiry; sustain just wraps its count
        if (cmd.advance && live && (tick_count_reg == phase_length_reg))
        begin
            tick_count_next = '0;
            case (phase_reg)
                adsr_pkg::PH_ATTACK:
                begin
                    if (decay_ticks_reg != '0)
                    begin
                        phase_next        = adsr_pkg::PH_DECAY;
                        phase_length_next = decay_ticks_reg;
                    end
                    else
                    begin
                        phase_next        = adsr_pkg::PH_SUSTAIN;
                        phase_length_next = adsr_pkg::HOLD_LENGTH;
                    end
                end
                adsr_pkg::PH_DECAY:
                begin
                    phase_next        = adsr_pkg::PH_SUSTAIN;
                    phase_length_next = adsr_pkg::HOLD_LENGTH;
                end
                adsr_pkg::PH_RELEASE: phase_next = adsr_pkg::PH_ENDED;
                default: ;
            endcase
        end

        if (cmd.prep && ramped && ramp_full)
        begin
            ramp_next = ramp_range;
        end

        if (cmd.shape)
        begin
            ramp_next = exp_mode_reg ? scaled[15:8] : quotient;
        end

        if (cmd.emit && live)
        begin
            tick_count_next = tick_count_reg + 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= adsr_pkg::PH_DISABLED;
            tick_count_reg   <= '0;
            phase_length_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            phase_length_reg <= phase_length_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ramp_reg <= ramp_next;
        if (cmd.emit)
        begin
            out_level_reg <= level_now;
            out_phase_reg <= phase_reg;
        end
    end

    assign status.ramped    = ramped;
    assign status.ramp_full = ramp_full;
    assign status.div_busy  = div_busy;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_level = out_level_reg;
    assign out_phase = out_phase_reg;

endmodule

// ===== sv/adsr_ctrl.sv =====
// Controller state machine sequencing one envelope transaction at a time.
`timescale 1ns / 1ps

module adsr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_op,
    output logic                  in_ready,
    input  adsr_pkg::dp_status_t  status,
    output adsr_pkg::ctrl_cmd_t   cmd
);

    adsr_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= adsr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            adsr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == adsr_pkg::OP_SET)
                    begin
                        cmd.set_phase = 1'b1;
                    end
                    else
                    begin
                        state_next = adsr_pkg::ST_ADVANCE;
                    end
                end
            end
            adsr_pkg::ST_ADVANCE:
            begin
                cmd.advance = 1'b1;
                state_next  = adsr_pkg::ST_PREP;
            end
            adsr_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
                if (status.ramped && !status.ramp_full)
                begin
                    state_next = adsr_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = adsr_pkg::ST_EMIT;
                end
            end
            adsr_pkg::ST_DIVIDE:
            begin
                if (!status.div_busy)
                begin
                    state_next = adsr_pkg::ST_SHAPE;
                end
            end
            adsr_pkg::ST_SHAPE:
            begin
                cmd.shape  = 1'b1;
                state_next = adsr_pkg::ST_EMIT;
            end
            adsr_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = adsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = adsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/adsr_envelope_generator.sv =====
// Top level of the ADSR envelope generator: controller, datapath and checks.
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+-------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: operation; tdata: new_phase
//  m_      | out | m_tvalid/m_tready  | tdata: level, phase_now
//  cfg_    | in  | cfg_wen            | cfg_index, cfg_data
//
// A tick whose ramp needs a division runs advance, prep, divide, shape and emit before
// the next acceptance; the 8-step restoring divider (one quotient bit a cycle) sets its length.
// Other ticks skip divide and shape; a set-phase transaction is taken in idle with no result.
// Results sit in an output register, so a new transaction is taken while the last
// result waits; a tick only stalls in its final cycle if that register is still full.
// Reset is asynchronous and active low; there is no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adsr_envelope_generator (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] new_phase, [7:3] zero
    input  logic [0:0]  s_tuser,   // [0] operation: 0 tick, 1 set phase

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] level, [10:8] phase_now, [15:11] zero

    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    adsr_pkg::ctrl_cmd_t  cmd;
    adsr_pkg::dp_status_t status;
    logic [7:0]           out_level;
    logic [2:0]           out_phase;

    // Sequencing; only a tick transaction leaves the idle state
    adsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_op    (s_tuser[0]),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Envelope state, ramp arithmetic and the output register
    adsr_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .new_phase (s_tdata[2:0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_level (out_level),
        .out_phase (out_phase)
    );

    assign m_tdata = {5'd0, out_phase, out_level};

    // A result is only loaded when the output register can take it
    `ASSERT_ALWAYS(a_emit_slot_free, cmd.emit |-> status.out_free, "emit into a full output register")

    // The controller issues at most one datapath command a cycle
    `ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.set_phase, cmd.advance, cmd.prep, cmd.shape, cmd.emit}), "several datapath commands at once")

    // No transaction is taken while the divider runs
    `ASSERT_ALWAYS(a_busy_no_accept, status.div_busy |-> !s_tready, "input accepted during a division")

    // A tick transaction occupies the block past its acceptance cycle
    `ASSERT_NEXT(a_tick_holds, s_tvalid && s_tready && (s_tuser[0] == adsr_pkg::OP_TICK), !s_tready, "tick did not block the next transaction")

endmodule
